FILE: rtl/greedy_box_suppressor_assert.svh
// assertion macros for the box suppressor
`ifndef GREEDY_BOX_SUPPRESSOR_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/gbs_pkg.sv
// shared constants and types for the box suppressor
`timescale 1ns / 1ps
package gbs_pkg;
  localparam int unsigned MAX_KEPT_DEF = 128;
  localparam logic [15:0] IOU_RESET = 16'd42598;

  // box geometry as stored in the kept list
  typedef struct packed {
    logic [14:0]        h;
    logic [14:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } box_t;

  // one-dimensional overlap of two spans, at most 17 bits
  function automatic logic [16:0] span(input logic signed [15:0] a0, input logic [14:0] alen,
                                       input logic signed [15:0] b0, input logic [14:0] blen);
    logic signed [17:0] lo;
    logic signed [17:0] ea;
    logic signed [17:0] eb;
    logic signed [17:0] hi;
    logic signed [17:0] d;
    lo = (a0 > b0) ? 18'(a0) : 18'(b0);
    ea = 18'(a0) + $signed({3'b000, alen});
    eb = 18'(b0) + $signed({3'b000, blen});
    hi = (ea < eb) ? ea : eb;
    d  = hi - lo;
    span = (hi > lo) ? d[16:0] : 17'd0;
  endfunction
endpackage

FILE: rtl/gbs_overlap.sv
// pipelined intersection-over-union compare against one kept box
`timescale 1ns / 1ps
`include "greedy_box_suppressor_assert.svh"
module gbs_overlap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  gbs_pkg::box_t     cur_i,
  input  gbs_pkg::box_t     kept_i,
  input  logic              lbl_eq_i,
  input  logic [15:0]       thr_i,
  output logic              vld_o,
  output logic              hit_o
);
  // stage 1: spans and areas
  logic        s1_vld_r;
  logic        s1_eq_r;
  logic [16:0] s1_sx_r;
  logic [16:0] s1_sy_r;
  logic [29:0] s1_aa_r;
  logic [29:0] s1_ab_r;
  // stage 2: intersection and area sum
  logic        s2_vld_r;
  logic        s2_eq_r;
  logic [33:0] s2_in_r;
  logic [30:0] s2_as_r;
  // stage 3: union
  logic        s3_vld_r;
  logic        s3_eq_r;
  logic [33:0] s3_in_r;
  logic [30:0] s3_un_r;
  // stage 4: threshold product and zero-union flag
  logic        s4_vld_r;
  logic        s4_eq_r;
  logic [33:0] s4_in_r;
  logic        s4_z_r;
  logic [46:0] s4_pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    s1_eq_r <= lbl_eq_i;
    s1_sx_r <= gbs_pkg::span(cur_i.x, cur_i.w, kept_i.x, kept_i.w);
    s1_sy_r <= gbs_pkg::span(cur_i.y, cur_i.h, kept_i.y, kept_i.h);
    s1_aa_r <= 30'(cur_i.w) * 30'(cur_i.h);
    s1_ab_r <= 30'(kept_i.w) * 30'(kept_i.h);
    s2_eq_r <= s1_eq_r;
    s2_in_r <= 34'(s1_sx_r) * 34'(s1_sy_r);
    s2_as_r <= 31'(s1_aa_r) + 31'(s1_ab_r);
    s3_eq_r <= s2_eq_r;
    s3_in_r <= s2_in_r;
    // intersection never exceeds either area, so this never goes negative
    s3_un_r <= s2_as_r - s2_in_r[30:0];
    s4_eq_r <= s3_eq_r;
    s4_in_r <= s3_in_r;
    s4_z_r  <= (s3_un_r == 31'd0);
    s4_pr_r <= 47'(s3_un_r) * 47'(thr_i);
  end

  assign vld_o = s4_vld_r;
  assign hit_o = s4_eq_r && !s4_z_r && ({s4_in_r, 16'h0000} > 50'(s4_pr_r));

  `GBS_ASSERT_NXT(a_pipe_flow, clk, rst_n, vld_i, s1_vld_r)
  `GBS_ASSERT_IMP(a_zero_union, clk, rst_n, s4_vld_r && s4_z_r, !hit_o)
  `GBS_ASSERT_IMP(a_label_gate, clk, rst_n, s4_vld_r && !s4_eq_r, !hit_o)
endmodule

FILE: rtl/greedy_box_suppressor.sv
// greedy non-maximum suppression top level
// one store read per kept box per cycle into the store read register and compare pipeline, early stop on a hit
// one box at a time, the next beat is taken at the edge that drains the result
// reset: synchronous active-low rst_n clears count, index, fsm; threshold to 42598
`timescale 1ns / 1ps
`include "greedy_box_suppressor_assert.svh"
module greedy_box_suppressor #(
  parameter int unsigned MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,          // iou_threshold
  input  logic        in_tvalid,
  output logic        in_tready,
  // box_x[15:0], box_y[31:16], box_width[46:32], box_height[61:47], class_label[69:62]
  input  logic [71:0] in_tdata,
  input  logic        in_tuser,          // first_of_set
  output logic        out_tvalid,
  input  logic        out_tready,
  // box_index[15:0], keep[16], not_stored[17]
  output logic [23:0] out_tdata
);
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_KEPT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // kept list memories
  gbs_pkg::box_t box_mem [MAX_KEPT];
  logic [7:0]    lbl_mem [MAX_KEPT];
  gbs_pkg::box_t rd_box_r;
  logic [7:0]    rd_lbl_r;

  logic [1:0]    st_r, st_nxt;
  logic [15:0]   thr_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   idx_r;
  gbs_pkg::box_t cur_r;
  logic [7:0]    lbl_r;
  logic [CW-1:0] rd_ptr_r;      // next address to issue
  logic [CW-1:0] ret_r;         // compares returned so far
  logic          rd_vld_r;
  logic          hit_r;
  logic          ov_vld;
  logic          ov_hit;
  logic          out_vld_r;
  logic [17:0]   out_r;
  logic          accept;
  logic          issue;
  logic          scan_end;
  logic [CW-1:0] ret_inc;
  logic          drained;

  assign cfg_ready = 1'b1;
  // a new box waits for idle and for the result register to be free or draining
  assign in_tready = (st_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign issue     = (st_r == ST_SCAN) && !hit_r && (rd_ptr_r < cnt_r);
  assign ret_inc   = ret_r + CW'(ov_vld);
  assign scan_end  = (st_r == ST_SCAN) && ((hit_r || (ov_vld && ov_hit)) ?
                     1'b1 : (ret_inc == cnt_r));
  // in-flight reads drain before the stage closes even after a hit
  assign drained = (ret_inc == rd_ptr_r) && !issue;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_SCAN;
      ST_SCAN: if (scan_end && drained) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_box_r <= box_mem[rd_ptr_r[AW-1:0]];
      rd_lbl_r <= lbl_mem[rd_ptr_r[AW-1:0]];
    end
    if (st_r == ST_DONE && !hit_r && cnt_r < CMAX) begin
      box_mem[cnt_r[AW-1:0]] <= cur_r;
      lbl_mem[cnt_r[AW-1:0]] <= lbl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      thr_r     <= gbs_pkg::IOU_RESET;
      cnt_r     <= '0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
      rd_ptr_r  <= '0;
      ret_r     <= '0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= issue;
      if (cfg_valid) thr_r <= cfg_data;
      if (out_vld_r && out_tready) out_vld_r <= 1'b0;
      if (accept) begin
        cur_r    <= gbs_pkg::box_t'{h: in_tdata[61:47], w: in_tdata[46:32],
                                    y: in_tdata[31:16], x: in_tdata[15:0]};
        lbl_r    <= in_tdata[69:62];
        hit_r    <= 1'b0;
        rd_ptr_r <= '0;
        ret_r    <= '0;
        if (in_tuser) begin
          cnt_r <= '0;
          idx_r <= '0;
        end
      end
      if (st_r == ST_SCAN) begin
        if (issue) rd_ptr_r <= rd_ptr_r + CW'(1);
        ret_r <= ret_inc;
        if (ov_vld && ov_hit) hit_r <= 1'b1;
      end
      if (st_r == ST_DONE) begin
        out_vld_r <= 1'b1;
        out_r     <= {!hit_r && (cnt_r == CMAX), !hit_r, idx_r};
        idx_r     <= idx_r + 16'd1;
        if (!hit_r && cnt_r < CMAX) cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  gbs_overlap u_ov (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (rd_vld_r),
    .cur_i    (cur_r),
    .kept_i   (rd_box_r),
    .lbl_eq_i (rd_lbl_r == lbl_r),
    .thr_i    (thr_r),
    .vld_o    (ov_vld),
    .hit_o    (ov_hit)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b000000, out_r};

  `GBS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CMAX)
  `GBS_ASSERT_IMP(a_ns_keep, clk, rst_n, out_vld_r, !out_r[17] || out_r[16])
  `GBS_ASSERT_NXT(a_done_out, clk, rst_n, st_r == ST_DONE, out_vld_r)
  `GBS_ASSERT_IMP(a_ret_bound, clk, rst_n, st_r == ST_SCAN, ret_r <= rd_ptr_r)
endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the greedy box suppressor
`timescale 1ns / 1ps
module tb_top;
  localparam int KEPT_DEPTH = 128;
  localparam int N_RANDOM = 1800;
  localparam int IDLE_LIMIT = 20000;

  // one input beat
  typedef struct {
    logic               first;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [7:0]         label;
  } box_beat_t;

  // one verdict beat
  typedef struct {
    logic [15:0] index;
    logic        keep;
    logic        not_stored;
  } verdict_t;

  // directed row: the box, and a typed-in verdict where it is obvious
  typedef struct {
    box_beat_t b;
    logic      fixed;
    verdict_t  v;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;    // box_x, box_y, box_width, box_height, class_label, pad
  logic        in_tuser;    // first_of_set
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // box_index, keep, not_stored, pad

  greedy_box_suppressor u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state: its own copy of the kept list and threshold
  gbs_pkg::box_t kept_geom[KEPT_DEPTH];
  logic [7:0]    kept_cls[KEPT_DEPTH];
  int            n_kept;
  logic [15:0]   box_counter;
  logic [15:0]   iou_limit;

  verdict_t verdict_q[$];
  row_t     rows[$];
  int       n_fail;
  int       n_mismatch;
  int       idle_cycles;
  bit       hold_sink;   // long receiver stall requested

  function automatic logic [16:0] overlap_1d(logic signed [15:0] a0, logic [14:0] al,
                                             logic signed [15:0] b0, logic [14:0] bl);
    int lo, hi, ea, eb;
    lo = (a0 > b0) ? a0 : b0;
    ea = int'(a0) + int'(al);
    eb = int'(b0) + int'(bl);
    hi = (ea < eb) ? ea : eb;
    return (hi > lo) ? 17'(hi - lo) : 17'd0;
  endfunction

  function automatic bit too_close(box_beat_t a, gbs_pkg::box_t k);
    logic [63:0] inter, area_a, area_k, uni;
    inter  = 64'(overlap_1d(a.x, a.w, k.x, k.w)) * 64'(overlap_1d(a.y, a.h, k.y, k.h));
    area_a = 64'(a.w) * 64'(a.h);
    area_k = 64'(k.w) * 64'(k.h);
    uni    = area_a + area_k - inter;
    if (uni == 0) return 1'b0;
    return (inter << 16) > 64'(iou_limit) * uni;
  endfunction

  // runs one box through the suppression rule and updates the kept list
  function automatic verdict_t suppress_box(box_beat_t b);
    verdict_t v;
    if (b.first) begin
      n_kept = 0;
      box_counter = 16'd0;
    end
    v.keep = 1'b1;
    v.not_stored = 1'b0;
    for (int i = 0; i < n_kept; i++)
      if (kept_cls[i] == b.label && too_close(b, kept_geom[i])) begin
        v.keep = 1'b0;
        break;
      end
    if (v.keep) begin
      if (n_kept < KEPT_DEPTH) begin
        kept_geom[n_kept] = '{h: b.h, w: b.w, y: b.y, x: b.x};
        kept_cls[n_kept] = b.label;
        n_kept++;
      end else begin
        v.not_stored = 1'b1;
      end
    end
    v.index = box_counter;
    box_counter++;
    return v;
  endfunction

  function automatic void add_row(box_beat_t b, logic fixed, verdict_t v);
    row_t r;
    r.b = b;
    r.fixed = fixed;
    r.v = v;
    rows.insert(rows.size(), r);
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    n_fail++;
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
  endtask

  // source idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_box(box_beat_t b, bit fixed, verdict_t v);
    verdict_t p;
    int gap;
    in_tdata  <= {2'b00, b.label, b.h, b.w, b.y, b.x};
    in_tuser  <= b.first;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge
    p = suppress_box(b);
    verdict_q.insert(verdict_q.size(), fixed ? v : p);
    if (fixed && ((p.index != v.index) || (p.keep != v.keep) ||
                  (p.not_stored != v.not_stored)))
      report("typed verdict vs predictor", {p.index, p.keep, p.not_stored},
             {v.index, v.keep, v.not_stored});
    gap = ($urandom_range(0, 2) != 0) ? gap_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_threshold(logic [15:0] t);
    in_tvalid <= 1'b0;
    // settle: drain results, then wait out any box still in flight
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (KEPT_DEPTH + 20) @(posedge clk);
    cfg_data  <= t;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iou_limit = t;
  endtask

  function automatic box_beat_t rand_box(bit first, logic [7:0] nlabels, bit cluster);
    box_beat_t b;
    b.first = first;
    if (cluster) begin
      b.x = 16'($signed($urandom_range(0, 800)) - 400);
      b.y = 16'($signed($urandom_range(0, 800)) - 400);
      b.w = 15'($urandom_range(0, 600));
      b.h = 15'($urandom_range(0, 600));
    end else begin
      b.x = 16'($urandom);
      b.y = 16'($urandom);
      b.w = 15'($urandom);
      b.h = 15'($urandom);
    end
    b.label = 8'($urandom_range(0, nlabels));
    return b;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 80)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      @(posedge clk);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
          || hold_sink)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report("beat with nothing expected", 0, 32'(out_tdata));
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (out_tdata[15:0] != e.index) report("box_index", e.index, out_tdata[15:0]);
          if (out_tdata[16] != e.keep) report("keep", e.keep, out_tdata[16]);
          if (out_tdata[17] != e.not_stored) report("not_stored", e.not_stored, out_tdata[17]);
        end
      end
    end
  end

  initial begin
    box_beat_t b;
    verdict_t none;
    int sent;
    n_fail = 0; n_mismatch = 0; idle_cycles = 0;
    hold_sink = 1'b0;
    n_kept = 0; box_counter = 16'd0; iou_limit = gbs_pkg::IOU_RESET;
    none = '{16'd0, 1'b0, 1'b0};
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = 16'd0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: first box after reset is always kept at index 0
    add_row('{1, 16'sd0, 16'sd0, 15'd160, 15'd160, 8'd3}, 1, '{16'd0, 1, 0});
    // identical box, same label: full overlap suppresses
    add_row('{0, 16'sd0, 16'sd0, 15'd160, 15'd160, 8'd3}, 1, '{16'd1, 0, 0});
    // identical box, other label: kept
    add_row('{0, 16'sd0, 16'sd0, 15'd160, 15'd160, 8'd4}, 1, '{16'd2, 1, 0});
    // zero-area boxes: union zero counts as no overlap
    add_row('{0, 16'sd50, 16'sd50, 15'd0, 15'd0, 8'd9}, 1, '{16'd3, 1, 0});
    add_row('{0, 16'sd50, 16'sd50, 15'd0, 15'd0, 8'd9}, 1, '{16'd4, 1, 0});
    // field extremes, edges at full width
    add_row('{0, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 8'hff}, 0, none);
    add_row('{0, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 8'hff}, 0, none);
    add_row('{0, -16'sh8000, -16'sh8000, 15'h7fff, 15'h7fff, 8'h00}, 0, none);
    add_row('{0, -16'sh7000, -16'sh8000, 15'h7fff, 15'h7fff, 8'h00}, 0, none);
    add_row('{0, 16'sd100, 16'sd0, 15'd160, 15'd160, 8'd3}, 0, none);
    add_row('{0, 16'sd10, 16'sd10, 15'd160, 15'd160, 8'd3}, 0, none);
    // new set restarts the index
    add_row('{1, 16'sd0, 16'sd0, 15'd160, 15'd160, 8'd3}, 1, '{16'd0, 1, 0});
    foreach (rows[i]) send_box(rows[i].b, rows[i].fixed, rows[i].v);

    // threshold zero: any positive overlap suppresses
    write_threshold(16'd0);
    send_box('{1, 16'sd0, 16'sd0, 15'd100, 15'd100, 8'd1}, 1, '{16'd0, 1, 0});
    send_box('{0, 16'sd99, 16'sd99, 15'd100, 15'd100, 8'd1}, 1, '{16'd1, 0, 0});
    send_box('{0, 16'sd100, 16'sd0, 15'd100, 15'd100, 8'd1}, 1, '{16'd2, 1, 0});
    // threshold max: almost nothing suppressed
    write_threshold(16'hffff);
    send_box('{1, 16'sd0, 16'sd0, 15'd100, 15'd100, 8'd1}, 1, '{16'd0, 1, 0});
    send_box('{0, 16'sd0, 16'sd0, 15'd100, 15'd100, 8'd1}, 1, '{16'd1, 0, 0});
    send_box('{0, 16'sd1, 16'sd0, 15'd100, 15'd100, 8'd1}, 0, none);

    // full list: 128 disjoint boxes then overflow reports not_stored
    write_threshold(gbs_pkg::IOU_RESET);
    for (int i = 0; i < KEPT_DEPTH + 3; i++) begin
      b = '{i == 0, 16'(i * 64), 16'sd0, 15'd32, 15'd32, 8'd7};
      send_box(b, 0, none);
      if (i == 20) hold_sink = 1'b1;   // long receiver stall while the source keeps offering boxes
    end

    // random part in phases of thresholds
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent % 400 == 0) write_threshold(16'($urandom));
      b = rand_box(($urandom_range(0, 39) == 0), 8'($urandom_range(0, 3) == 0 ? 255 : 2),
                   ($urandom_range(0, 9) != 0));
      send_box(b, 0, none);
      sent++;
    end
    in_tvalid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (KEPT_DEPTH + 20) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
